### hdl/ffha_pkg.sv
// ffha_pkg: shared constants and types for the first-fit heap allocator
// used by ffha_hdr_mem and first_fit_heap_allocator; no dependencies
package ffha_pkg;

    localparam int HEAP_BYTES_DEFAULT = 4096;

    localparam int REQ_W    = 13;  // request_size width
    localparam int OFF_IN_W = 13;  // free_offset width
    localparam int OFFSET_W = 12;  // payload_offset width
    localparam int NEED_W   = 11;  // chunk size in granules derived from a request
    localparam int STATUS_W = 3;

    // smallest remainder in granules that is split off as its own chunk
    localparam int MIN_SPLIT_GRAN = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_NO_SPACE      = 3'd1,
        ST_ZERO_SIZE     = 3'd2,
        ST_BAD_POINTER   = 3'd3,
        ST_NOT_ALLOCATED = 3'd4
    } status_t;

endpackage

### hdl/ffha_hdr_mem.sv
// ffha_hdr_mem: single-port-write, single-port-read header store, one entry per granule
// read data registered; depends on ffha_pkg
module ffha_hdr_mem
    import ffha_pkg::*;
#(
    parameter int DEPTH = HEAP_BYTES_DEFAULT / 8,
    parameter int WIDTH = 11
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/first_fit_heap_allocator.sv
// first_fit_heap_allocator: implicit-list first-fit allocator over a byte heap
// a zero-size allocate or an out-of-range free is answered from idle, with no walk;
// otherwise the walk visits headers in order, and a free that merges reads the next chunk.
// busy stays high until the last header write, so a split keeps it high through S_SPLIT;
// no new request is taken until busy falls; the walk over the header memory (one read per cycle) sets the rate.
// reset: state S_INIT writes header 0 as the whole heap free; busy is high meanwhile.
// results are strobed on done for one cycle and cannot be stalled; depends on ffha_pkg
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                command,
    input  logic [REQ_W-1:0]    request_size,
    input  logic [OFF_IN_W-1:0] free_offset,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [OFFSET_W-1:0] payload_offset
);

    localparam int GRANULES = HEAP_BYTES / 8;
    localparam int AW       = $clog2(GRANULES);
    localparam int SZW      = $clog2(GRANULES + 1);
    localparam int HW       = SZW + 1;
    localparam int CW       = (SZW > NEED_W) ? SZW : NEED_W;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WALK,
        S_MERGE,
        S_SPLIT
    } state_t;

    state_t              state_reg, state_next;
    logic                cmd_reg, cmd_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [OFF_IN_W-1:0] off_reg, off_next;
    logic [SZW-1:0]      pos_reg, pos_next;
    logic [SZW-1:0]      sz_reg, sz_next;
    logic [SZW-1:0]      split_pos_reg, split_pos_next;
    logic [SZW-1:0]      rest_reg, rest_next;
    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [OFFSET_W-1:0] payload_reg, payload_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [HW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [HW-1:0] mem_rdata;

    // header word: {allocated, size in granules}
    logic           hdr_used;
    logic [SZW-1:0] hdr_size;
    logic [SZW:0]   pos_sum;
    logic           sum_end;
    logic           fits;
    logic [CW-1:0]  rest_wide;
    logic [SZW-1:0] rest;
    logic           match;
    logic [31:0]    payload_wide;
    logic [SZW-1:0] merged;

    assign hdr_used     = mem_rdata[SZW];
    assign hdr_size     = mem_rdata[SZW-1:0];
    assign pos_sum      = {1'b0, pos_reg} + {1'b0, hdr_size};
    assign sum_end      = pos_sum >= (SZW+1)'(GRANULES);
    assign fits         = !hdr_used && (CW'(hdr_size) >= CW'(need_reg));
    assign rest_wide    = CW'(hdr_size) - CW'(need_reg);
    assign rest         = rest_wide[SZW-1:0];
    assign match        = (off_reg[2:0] == 3'd0)
                          && (32'(off_reg[OFF_IN_W-1:3]) == 32'(pos_reg) + 32'd1);
    assign payload_wide = (32'(pos_reg) + 32'd1) << 3;
    assign merged       = sz_reg + hdr_size;

    ffha_hdr_mem #(
        .DEPTH(GRANULES),
        .WIDTH(HW)
    ) u_hdr_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        need_next      = need_reg;
        off_next       = off_reg;
        pos_next       = pos_reg;
        sz_next        = sz_reg;
        split_pos_next = split_pos_reg;
        rest_next      = rest_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        payload_next   = payload_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg[AW-1:0];
        mem_wdata      = {1'b0, pos_reg};
        mem_raddr      = '0;

        unique case (state_reg)
            S_INIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = {1'b0, SZW'(GRANULES)};
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                // header 0 is read here so the walk sees it on the next cycle
                mem_raddr = '0;
                if (start)
                begin
                    cmd_next     = command;
                    need_next    = NEED_W'((14'(request_size) + 14'd7) >> 3) + NEED_W'(1);
                    off_next     = free_offset;
                    pos_next     = '0;
                    payload_next = '0;
                    if (command == CMD_ALLOC && request_size == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_ZERO_SIZE;
                    end
                    else if (command == CMD_FREE && 32'(free_offset) >= 32'(HEAP_BYTES))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_BAD_POINTER;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                // prefetch the following header while this one is examined
                mem_raddr = sum_end ? '0 : pos_sum[AW-1:0];
                if (hdr_size == '0)
                begin
                    done_next   = 1'b1;
                    status_next = (cmd_reg == CMD_ALLOC) ? ST_NO_SPACE : ST_BAD_POINTER;
                    state_next  = S_IDLE;
                end
                else if (cmd_reg == CMD_ALLOC && fits)
                begin
                    done_next    = 1'b1;
                    status_next  = ST_OK;
                    payload_next = payload_wide[OFFSET_W-1:0];
                    mem_we       = 1'b1;
                    if (rest >= SZW'(MIN_SPLIT_GRAN))
                    begin
                        mem_wdata      = {1'b1, SZW'(need_reg)};
                        split_pos_next = pos_reg + SZW'(need_reg);
                        rest_next      = rest;
                        state_next     = S_SPLIT;
                    end
                    else
                    begin
                        mem_wdata  = {1'b1, hdr_size};
                        state_next = S_IDLE;
                    end
                end
                else if (cmd_reg == CMD_FREE && match)
                begin
                    if (!hdr_used)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NOT_ALLOCATED;
                        state_next  = S_IDLE;
                    end
                    else if (sum_end)
                    begin
                        mem_we      = 1'b1;
                        mem_wdata   = {1'b0, hdr_size};
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        sz_next    = hdr_size;
                        state_next = S_MERGE;
                    end
                end
                else if (sum_end)
                begin
                    done_next   = 1'b1;
                    status_next = (cmd_reg == CMD_ALLOC) ? ST_NO_SPACE : ST_BAD_POINTER;
                    state_next  = S_IDLE;
                end
                else
                begin
                    pos_next = pos_sum[SZW-1:0];
                end
            end

            S_MERGE:
            begin
                // next chunk header is on the read port now
                mem_we      = 1'b1;
                mem_wdata   = (hdr_size != '0 && !hdr_used) ? {1'b0, merged} : {1'b0, sz_reg};
                done_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
            end

            S_SPLIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = split_pos_reg[AW-1:0];
                mem_wdata  = {1'b0, rest_reg};
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        need_reg      <= need_next;
        off_reg       <= off_next;
        pos_reg       <= pos_next;
        sz_reg        <= sz_next;
        split_pos_reg <= split_pos_next;
        rest_reg      <= rest_next;
        payload_reg   <= payload_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign payload_offset = payload_reg;

endmodule
